>>> rtl/core/nonoverlap_substring_counter_assert.svh
// Assertion macros used by the RTL of the substring counter.
`ifndef NONOVERLAP_SUBSTRING_COUNTER_ASSERT_SVH
`define NONOVERLAP_SUBSTRING_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/nsc_pkg.sv
`default_nettype none

package nsc_pkg;

    localparam int PAT_BYTES     = 16;
    localparam int PAT_IDX_W     = 4;
    localparam int LEN_W         = 5;
    localparam int COOL_W        = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int MATCH_COUNT_W = 16;

    typedef logic [7:0] t_byte;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_LOW    = 2'd1,
        CFG_PATTERN_HIGH   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/core/nsc_in_if.sv
`default_nettype none

interface nsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> rtl/core/nsc_out_if.sv
`default_nettype none

interface nsc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_count;
    logic        match_here;
    logic        final_result;

    modport source (output valid, output match_count, output match_here,
                    output final_result, input ready);
    modport sink   (input valid, input match_count, input match_here,
                    input final_result, output ready);
endinterface

`default_nettype wire

>>> rtl/core/nsc_cell.sv
`default_nettype none

module nsc_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nsc_pkg::t_cell_ctl i_ctl,
    input  wire nsc_pkg::t_byte    i_byte,
    input  wire nsc_pkg::t_byte    i_pat,
    input  wire logic              i_en,
    output nsc_pkg::t_byte         o_byte,
    output logic                   o_hit
);
    import nsc_pkg::*;

    t_byte r_byte;
    t_byte n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_en || (i_byte == i_pat);

endmodule

`default_nettype wire

>>> rtl/core/nsc_ctrl.sv
`default_nettype none

`include "nonoverlap_substring_counter_assert.svh"

module nsc_ctrl #(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    nsc_in_if.sink                     i_text,
    nsc_out_if.source                  o_match,
    input  wire logic [nsc_pkg::LEN_W-1:0] i_len,
    input  wire logic                  i_win_match,
    output nsc_pkg::t_cell_ctl         o_cell_ctl
);
    import nsc_pkg::*;

    localparam int SEEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W  = ((SEEN_W > LEN_W) ? SEEN_W : LEN_W) + 1;

    logic [SEEN_W-1:0]     r_seen;
    logic [SEEN_W-1:0]     n_seen;
    logic [COOL_W-1:0]     r_cooldown;
    logic [COOL_W-1:0]     n_cooldown;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] w_count_step;

    logic                     r_out_valid;
    logic [MATCH_COUNT_W-1:0] r_out_count;
    logic                     r_out_hit;
    logic                     r_out_last;

    logic                               w_ready;
    logic                               w_accept;
    logic                               w_last;
    logic                               w_hit;
    logic                               w_seen_ok;
    logic [CMP_W-1:0]                   w_seen_inc;
    logic [COOL_W-1:0]                  w_cool_load;
    logic [LEN_W-1:0]                   w_len_m1;
    logic [COUNT_BITS+MATCH_COUNT_W-1:0] w_count_ext;

    assign w_ready  = i_rst_n && (!r_out_valid || o_match.ready);
    assign w_accept = i_text.valid && w_ready;
    assign w_last   = i_text.end_of_text;

    assign w_seen_inc  = CMP_W'(r_seen) + CMP_W'(1);
    assign w_seen_ok   = w_seen_inc >= CMP_W'(i_len);
    assign w_len_m1    = i_len - LEN_W'(1);
    assign w_cool_load = w_len_m1[COOL_W-1:0];
    assign w_hit       = (i_len != '0) && w_seen_ok && (r_cooldown == '0) && i_win_match;

    always_comb begin
        w_count_step = r_count;
        if (w_hit && (r_count != '1)) begin
            w_count_step = r_count + COUNT_BITS'(1);
        end
        w_count_ext = {{MATCH_COUNT_W{1'b0}}, w_count_step};

        n_seen     = r_seen;
        n_cooldown = r_cooldown;
        n_count    = r_count;
        if (w_accept) begin
            if (w_last) begin
                n_seen     = '0;
                n_cooldown = '0;
                n_count    = '0;
            end else begin
                n_count = w_count_step;
                if (r_seen < SEEN_W'(MAX_PATTERN)) begin
                    n_seen = r_seen + SEEN_W'(1);
                end
                if (w_hit) begin
                    n_cooldown = w_cool_load;
                end else if (r_cooldown != '0) begin
                    n_cooldown = r_cooldown - COOL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_cooldown  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen     <= n_seen;
            r_cooldown <= n_cooldown;
            r_count    <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_match.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_count <= w_count_ext[MATCH_COUNT_W-1:0];
            r_out_hit   <= w_hit;
            r_out_last  <= w_last;
        end
    end

    assign i_text.ready         = w_ready;
    assign o_match.valid        = r_out_valid;
    assign o_match.match_count  = r_out_count;
    assign o_match.match_here   = r_out_hit;
    assign o_match.final_result = r_out_last;

    assign o_cell_ctl.shift = w_accept;
    assign o_cell_ctl.clear = w_accept && w_last;

    `NSC_ASSERT_NEXT(a_count_after_hit, i_clk, i_rst_n,
        w_accept && w_hit && !w_last, r_count != '0,
        "running count is zero after a counted match")
    `NSC_ASSERT_NEXT(a_cooldown_load, i_clk, i_rst_n,
        w_accept && w_hit && !w_last, r_cooldown == $past(w_cool_load),
        "cooldown not loaded with pattern length minus one after a match")
    `NSC_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n,
        w_accept && w_last, (r_seen == '0) && (r_cooldown == '0) && (r_count == '0),
        "string state not cleared after the final word")
    `NSC_ASSERT_SAME(a_out_load, i_clk, i_rst_n,
        $rose(r_out_valid), $past(w_accept),
        "output register filled without an accepted word")

endmodule

`default_nettype wire

>>> rtl/core/nonoverlap_substring_counter.sv
// Counts leftmost-first, non-overlapping occurrences of a pattern of up to 16 bytes in a
// stream of text words, one byte per word, the last byte of each string marked by
// end_of_text. Every accepted word yields one result word with the saturating running
// count, a flag for a counted match ending at that byte and the final flag; after the
// final word the string state clears while the pattern registers keep their values. The
// block accepts one word per cycle while the output is not stalled and presents its result
// in an output register in the cycle after acceptance; the rate is set by the combinational
// compare of the incoming byte and the byte window held in a row of MAX_PATTERN cells
// against the pattern. A stalled output holds its word while one more input word waits
// upstream. Pattern registers are to be written only while no string is in progress.
`default_nettype none

module nonoverlap_substring_counter #(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [nsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [nsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    nsc_in_if.sink                                i_text,
    nsc_out_if.source                             o_match
);
    import nsc_pkg::*;

    localparam int LEN_CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
    localparam int POS_BASE = ($clog2(MAX_PATTERN) > LEN_W) ? $clog2(MAX_PATTERN) : LEN_W;
    localparam int POS_W    = POS_BASE + 1;

    logic [LEN_W-1:0]      r_pat_len;
    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;

    logic [LEN_W-1:0]       w_len;
    t_byte                  w_pat [PAT_BYTES];
    t_byte                  w_win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_cell_hit;
    t_cell_ctl              w_cell_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len  <= '0;
            r_pat_low  <= '0;
            r_pat_high <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_pat_len  <= i_cfg_data[LEN_W-1:0];
                CFG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_len = (r_pat_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : r_pat_len;

    for (genvar i = 0; i < PAT_BYTES / 2; i++) begin : g_pat
        assign w_pat[i]                 = r_pat_low[8*i +: 8];
        assign w_pat[i + PAT_BYTES / 2] = r_pat_high[8*i +: 8];
    end

    assign w_win[0] = i_text.text_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        localparam logic [POS_W-1:0] KPOS = POS_W'(k);
        logic [POS_W-1:0] w_idx;
        logic             w_en;

        assign w_en  = POS_W'(w_len) > KPOS;
        assign w_idx = POS_W'(w_len) - POS_W'(1) - KPOS;

        if (k < MAX_PATTERN - 1) begin : g_mid
            nsc_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_cell_ctl),
                .i_byte (w_win[k]),
                .i_pat  (w_pat[w_idx[PAT_IDX_W-1:0]]),
                .i_en   (w_en),
                .o_byte (w_win[k+1]),
                .o_hit  (w_cell_hit[k])
            );
        end else begin : g_end
            nsc_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_cell_ctl),
                .i_byte (w_win[k]),
                .i_pat  (w_pat[w_idx[PAT_IDX_W-1:0]]),
                .i_en   (w_en),
                .o_byte (),
                .o_hit  (w_cell_hit[k])
            );
        end
    end

    nsc_ctrl #(
        .MAX_PATTERN(MAX_PATTERN),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_text     (i_text),
        .o_match    (o_match),
        .i_len      (w_len),
        .i_win_match(&w_cell_hit),
        .o_cell_ctl (w_cell_ctl)
    );

endmodule

`default_nettype wire
